>>> rtl/ffra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the first-fit region allocator.
// No dependencies.
package ffra_pkg;

    localparam int ADDR_W  = 20;
    localparam int LEN_W   = 21;
    localparam int WANT_W  = LEN_W + 1;
    localparam int ALIGN_M = 7;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_DROP_RD,
        S_A_DROP_WR,
        S_F_RD,
        S_F_CHK,
        S_F_DROP_RD,
        S_F_DROP_WR,
        S_F_POS_RD,
        S_F_POS_CHK,
        S_F_SH_RD,
        S_F_SH_WR,
        S_F_INS,
        S_FIN
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [LEN_W-1:0]  nbytes;
        logic [ADDR_W-1:0] addr;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_res;
        status_t           status;
    } out_t;

endpackage

>>> rtl/first_fit_region_allocator_top.sv
`timescale 1ns / 1ps
// First-fit region allocator: sorted free table and unordered used table,
// each held in a synchronous memory. Depends on ffra_pkg.
//
//  channel  | ports                      | moves
//  ---------+----------------------------+------------------------------
//  request  | s_valid s_ready s_in       | op, nbytes, addr
//  result   | m_valid m_ready m_out      | addr_res, status
//  config   | cfg_valid cfg_ready cfg_data | region_size
//
// An item walks the tables one entry at a time, with a read state and a
// check or write state per entry scanned or shifted, a pace set by the single
// read port of each table memory. Init goes from idle straight to the result.
// Reset is synchronous; it empties both tables, with no clearing pass.
// A result waits in the output register; the next request is taken while
// it waits and stalls only at its own end until the register is free.
module first_fit_region_allocator_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int OFFSET_BITS   = 20
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ffra_pkg::in_t              s_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ffra_pkg::out_t             m_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ffra_pkg::LEN_W-1:0] cfg_data
);

    localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int OB  = OFFSET_BITS;
    localparam int LW  = ffra_pkg::LEN_W;
    localparam int WW  = ffra_pkg::WANT_W;
    localparam int AdW = ffra_pkg::ADDR_W;
    localparam int EW  = OB + LW;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    ffra_pkg::state_t  state_reg, state_next;
    logic [LW-1:0]     region_reg;
    logic [CW-1:0]     free_count_reg, free_count_next;
    logic [CW-1:0]     used_count_reg, used_count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [WW-1:0]     want_reg, want_next;
    logic [OB-1:0]     addr_reg, addr_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [OB-1:0]     res_reg, res_next;
    ffra_pkg::status_t status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    ffra_pkg::out_t    m_out_reg, m_out_next;

    logic [EW-1:0] free_mem [TABLE_ENTRIES];
    logic [EW-1:0] used_mem [TABLE_ENTRIES];
    logic [EW-1:0] fr_rdata_reg, ud_rdata_reg;
    logic          fr_we, ud_we;
    logic [AW-1:0] fr_wa, fr_ra, ud_wa, ud_ra;
    logic [EW-1:0] fr_wd, ud_wd;

    logic [OB-1:0] fr_off, ud_off;
    logic [LW-1:0] fr_len, ud_len;
    logic          fits, exact, free_full, used_full;
    logic [CW:0]   idx_p1, idx_p2;
    logic [CW-1:0] idx_m1;
    logic [WW-1:0] req_want;

    assign fr_off    = fr_rdata_reg[EW-1:LW];
    assign fr_len    = fr_rdata_reg[LW-1:0];
    assign ud_off    = ud_rdata_reg[EW-1:LW];
    assign ud_len    = ud_rdata_reg[LW-1:0];
    assign fits      = {1'b0, fr_len} >= want_reg;
    assign exact     = {1'b0, fr_len} == want_reg;
    assign free_full = free_count_reg == FULL_COUNT;
    assign used_full = used_count_reg == FULL_COUNT;
    assign idx_p1    = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_p2    = {1'b0, idx_reg} + (CW+1)'(2);
    assign idx_m1    = idx_reg - CW'(1);
    assign req_want  = ({1'b0, s_in.nbytes} + WW'(ffra_pkg::ALIGN_M))
                       & ~WW'(ffra_pkg::ALIGN_M);

    assign s_ready   = state_reg == ffra_pkg::S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_out     = m_out_reg;

    // Table memories: one write and one registered read per cycle each.
    always_ff @(posedge aclk) begin
        if (fr_we) begin
            free_mem[fr_wa] <= fr_wd;
        end
        fr_rdata_reg <= free_mem[fr_ra];
    end

    always_ff @(posedge aclk) begin
        if (ud_we) begin
            used_mem[ud_wa] <= ud_wd;
        end
        ud_rdata_reg <= used_mem[ud_ra];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffra_pkg::S_IDLE: begin
                if (s_valid) begin
                    unique case (s_in.op)
                        ffra_pkg::OP_ALLOC: begin
                            state_next = (s_in.nbytes == '0) ? ffra_pkg::S_FIN
                                                             : ffra_pkg::S_A_RD;
                        end
                        ffra_pkg::OP_FREE: state_next = ffra_pkg::S_F_RD;
                        default:           state_next = ffra_pkg::S_FIN;
                    endcase
                end
            end
            ffra_pkg::S_A_RD: begin
                state_next = (idx_reg == free_count_reg) ? ffra_pkg::S_FIN
                                                         : ffra_pkg::S_A_CHK;
            end
            ffra_pkg::S_A_CHK: begin
                priority if (!fits) begin
                    state_next = ffra_pkg::S_A_RD;
                end else if (!used_full && exact && idx_p1 < {1'b0, free_count_reg}) begin
                    state_next = ffra_pkg::S_A_DROP_RD;
                end else begin
                    state_next = ffra_pkg::S_FIN;
                end
            end
            ffra_pkg::S_A_DROP_RD: state_next = ffra_pkg::S_A_DROP_WR;
            ffra_pkg::S_A_DROP_WR: begin
                state_next = (idx_p2 < {1'b0, free_count_reg}) ? ffra_pkg::S_A_DROP_RD
                                                               : ffra_pkg::S_FIN;
            end
            ffra_pkg::S_F_RD: begin
                state_next = (idx_reg == used_count_reg) ? ffra_pkg::S_FIN
                                                         : ffra_pkg::S_F_CHK;
            end
            ffra_pkg::S_F_CHK: begin
                priority if (ud_off != addr_reg) begin
                    state_next = ffra_pkg::S_F_RD;
                end else if (free_full) begin
                    state_next = ffra_pkg::S_FIN;
                end else if (idx_p1 < {1'b0, used_count_reg}) begin
                    state_next = ffra_pkg::S_F_DROP_RD;
                end else begin
                    state_next = ffra_pkg::S_F_POS_RD;
                end
            end
            ffra_pkg::S_F_DROP_RD: state_next = ffra_pkg::S_F_DROP_WR;
            ffra_pkg::S_F_DROP_WR: begin
                state_next = (idx_p2 < {1'b0, used_count_reg}) ? ffra_pkg::S_F_DROP_RD
                                                               : ffra_pkg::S_F_POS_RD;
            end
            ffra_pkg::S_F_POS_RD: begin
                state_next = (idx_reg == free_count_reg) ? ffra_pkg::S_F_INS
                                                         : ffra_pkg::S_F_POS_CHK;
            end
            ffra_pkg::S_F_POS_CHK: begin
                state_next = (fr_off <= addr_reg) ? ffra_pkg::S_F_POS_RD
                                                  : ffra_pkg::S_F_SH_RD;
            end
            ffra_pkg::S_F_SH_RD: state_next = ffra_pkg::S_F_SH_WR;
            ffra_pkg::S_F_SH_WR: begin
                state_next = (idx_m1 > pos_reg) ? ffra_pkg::S_F_SH_RD
                                                : ffra_pkg::S_F_INS;
            end
            ffra_pkg::S_F_INS: state_next = ffra_pkg::S_FIN;
            ffra_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default: state_next = ffra_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        free_count_next = free_count_reg;
        used_count_next = used_count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        want_next       = want_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg;
        m_out_next      = m_out_reg;
        fr_we           = 1'b0;
        fr_wa           = idx_reg[AW-1:0];
        fr_wd           = fr_rdata_reg;
        fr_ra           = idx_reg[AW-1:0];
        ud_we           = 1'b0;
        ud_wa           = idx_reg[AW-1:0];
        ud_wd           = ud_rdata_reg;
        ud_ra           = idx_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ffra_pkg::S_IDLE: begin
                if (s_valid) begin
                    want_next   = req_want;
                    addr_next   = OB'(s_in.addr);
                    idx_next    = '0;
                    res_next    = '0;
                    status_next = ffra_pkg::ST_OK;
                    if (s_in.op == ffra_pkg::OP_ALLOC && s_in.nbytes == '0) begin
                        status_next = ffra_pkg::ST_NO_SPACE;
                    end
                    if (s_in.op == ffra_pkg::OP_INIT) begin
                        fr_we           = 1'b1;
                        fr_wa           = '0;
                        fr_wd           = {OB'(0), region_reg};
                        free_count_next = CW'(1);
                        used_count_next = '0;
                    end
                end
            end
            ffra_pkg::S_A_RD: begin
                if (idx_reg == free_count_reg) begin
                    status_next = ffra_pkg::ST_NO_SPACE;
                end
            end
            ffra_pkg::S_A_CHK: begin
                if (!fits) begin
                    idx_next = idx_p1[CW-1:0];
                end else if (used_full) begin
                    status_next = ffra_pkg::ST_FULL;
                end else begin
                    ud_we           = 1'b1;
                    ud_wa           = used_count_reg[AW-1:0];
                    ud_wd           = {fr_off, want_reg[LW-1:0]};
                    used_count_next = used_count_reg + CW'(1);
                    res_next        = fr_off;
                    if (exact) begin
                        // Removing the last entry needs no shift.
                        if (!(idx_p1 < {1'b0, free_count_reg})) begin
                            free_count_next = free_count_reg - CW'(1);
                        end
                    end else begin
                        fr_we = 1'b1;
                        fr_wd = {fr_off + OB'(want_reg), fr_len - want_reg[LW-1:0]};
                    end
                end
            end
            ffra_pkg::S_A_DROP_RD: fr_ra = idx_p1[AW-1:0];
            ffra_pkg::S_A_DROP_WR: begin
                fr_we    = 1'b1;
                idx_next = idx_p1[CW-1:0];
                if (!(idx_p2 < {1'b0, free_count_reg})) begin
                    free_count_next = free_count_reg - CW'(1);
                end
            end
            ffra_pkg::S_F_RD: begin
                if (idx_reg == used_count_reg) begin
                    status_next = ffra_pkg::ST_NOTFOUND;
                end
            end
            ffra_pkg::S_F_CHK: begin
                if (ud_off != addr_reg) begin
                    idx_next = idx_p1[CW-1:0];
                end else if (free_full) begin
                    status_next = ffra_pkg::ST_FULL;
                end else begin
                    len_next = ud_len;
                    if (!(idx_p1 < {1'b0, used_count_reg})) begin
                        used_count_next = used_count_reg - CW'(1);
                        idx_next        = '0;
                    end
                end
            end
            ffra_pkg::S_F_DROP_RD: ud_ra = idx_p1[AW-1:0];
            ffra_pkg::S_F_DROP_WR: begin
                ud_we = 1'b1;
                if (idx_p2 < {1'b0, used_count_reg}) begin
                    idx_next = idx_p1[CW-1:0];
                end else begin
                    used_count_next = used_count_reg - CW'(1);
                    idx_next        = '0;
                end
            end
            ffra_pkg::S_F_POS_RD: begin
                if (idx_reg == free_count_reg) begin
                    pos_next = idx_reg;
                end
            end
            ffra_pkg::S_F_POS_CHK: begin
                // The new extent goes after every entry at or below its offset.
                if (fr_off <= addr_reg) begin
                    idx_next = idx_p1[CW-1:0];
                end else begin
                    pos_next = idx_reg;
                    idx_next = free_count_reg;
                end
            end
            ffra_pkg::S_F_SH_RD: fr_ra = idx_m1[AW-1:0];
            ffra_pkg::S_F_SH_WR: begin
                fr_we    = 1'b1;
                idx_next = idx_m1;
            end
            ffra_pkg::S_F_INS: begin
                fr_we           = 1'b1;
                fr_wa           = pos_reg[AW-1:0];
                fr_wd           = {addr_reg, len_reg};
                free_count_next = free_count_reg + CW'(1);
            end
            ffra_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_out_next.status   = status_reg;
                    m_out_next.addr_res = (status_reg == ffra_pkg::ST_OK) ? AdW'(res_reg)
                                                                          : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ffra_pkg::S_IDLE;
            region_reg     <= LW'(65536);
            free_count_reg <= '0;
            used_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            used_count_reg <= used_count_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                region_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        want_reg   <= want_next;
        addr_reg   <= addr_next;
        len_reg    <= len_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        m_out_reg  <= m_out_next;
    end

`ifndef SYNTHESIS
    a_free_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= FULL_COUNT)
        else $error("free table count exceeds its depth");
    a_used_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= FULL_COUNT)
        else $error("used table count exceeds its depth");
    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_out_reg.status != ffra_pkg::ST_OK |-> m_out_reg.addr_res == '0)
        else $error("failed request reports a nonzero offset");
    a_insert_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ffra_pkg::S_F_INS |-> free_count_reg < FULL_COUNT)
        else $error("insert into a full free table");
`endif

endmodule
